// ===== rtl/core/nhe_pkg.sv =====
// Shared types, constants and helper functions for the NAND Hamming ECC block.
package nhe_pkg;

    // Fixed field widths of the external words.
    localparam int EccW   = 24;
    localparam int AddrW  = 9;
    localparam int BitW   = 3;
    localparam int LenW   = 4;
    localparam int ByteW  = 8;
    localparam int CbW    = 5;

    // Register reset value and the pattern that picks the even bit of every pair.
    localparam logic [LenW-1:0] LenReset = 4'd8;
    localparam logic [EccW-1:0] OddMask  = 24'h555555;

    // Input operation codes.
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    // Result kinds.
    localparam logic KIND_GEN   = 1'b0;
    localparam logic KIND_CHECK = 1'b1;

    // Check outcomes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CORRECTED = 2'd1,
        ST_ECC_BAD   = 2'd2,
        ST_UNCORR    = 2'd3
    } t_status;

    // One record passed from the front to the back: a finished code or a check request.
    typedef struct packed {
        logic            is_check;
        logic [EccW-1:0] value;
    } t_rec;

    // Mask of the valid code bits for a block of 2^n bytes: 2*(n+3) bits.
    function automatic logic [EccW-1:0] ecc_mask(input logic [LenW-1:0] n);
        logic [CbW-1:0] cb;
        cb = {n, 1'b0} + CbW'(6);
        return ~({EccW{1'b1}} << cb);
    endfunction

endpackage

// ===== rtl/core/nhe_front.sv =====
// Front part: accumulates column and row parities per byte and forms records.
module nhe_front #(
    parameter int MAX_LEN_LOG2 = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [nhe_pkg::LenW-1:0]  i_len_log2,
    input  logic                      i_accept,
    input  logic                      i_op,
    input  logic [nhe_pkg::ByteW-1:0] i_data_byte,
    input  logic [nhe_pkg::EccW-1:0]  i_read_ecc,
    output logic                      o_rec_valid,
    output nhe_pkg::t_rec             o_rec
);
    import nhe_pkg::*;

    localparam int IdxW  = MAX_LEN_LOG2;
    localparam int RowW  = 2 * MAX_LEN_LOG2;

    logic [5:0]      r_col, n_col;
    logic [RowW-1:0] r_row, n_row;
    logic [IdxW-1:0] r_idx, n_idx;
    logic            rp;
    logic            last;
    logic [IdxW:0]   lim;
    logic [EccW-1:0] code;

    // Column parities and the byte's overall parity.
    always_comb begin
        rp       = ^i_data_byte;
        n_col    = r_col;
        n_col[0] = r_col[0] ^ i_data_byte[6] ^ i_data_byte[4] ^ i_data_byte[2] ^ i_data_byte[0];
        n_col[1] = r_col[1] ^ i_data_byte[7] ^ i_data_byte[5] ^ i_data_byte[3] ^ i_data_byte[1];
        n_col[2] = r_col[2] ^ i_data_byte[5] ^ i_data_byte[4] ^ i_data_byte[1] ^ i_data_byte[0];
        n_col[3] = r_col[3] ^ i_data_byte[7] ^ i_data_byte[6] ^ i_data_byte[3] ^ i_data_byte[2];
        n_col[4] = r_col[4] ^ i_data_byte[3] ^ i_data_byte[2] ^ i_data_byte[1] ^ i_data_byte[0];
        n_col[5] = r_col[5] ^ i_data_byte[7] ^ i_data_byte[6] ^ i_data_byte[5] ^ i_data_byte[4];
    end

    // Row parities: each index bit below n steers the byte parity into one bit of its pair.
    always_comb begin
        n_row = r_row;
        for (int i = 0; i < MAX_LEN_LOG2; i++) begin
            if (LenW'(i) < i_len_log2) begin
                if (r_idx[i]) begin
                    n_row[2*i+1] = r_row[2*i+1] ^ rp;
                end else begin
                    n_row[2*i] = r_row[2*i] ^ rp;
                end
            end
        end
    end

    // Block end detection and the finished code.
    always_comb begin
        lim   = (IdxW+1)'(1) << i_len_log2;
        last  = (({1'b0, r_idx} + (IdxW+1)'(1)) >= lim);
        n_idx = last ? '0 : r_idx + IdxW'(1);
        code  = EccW'({n_row, n_col}) & ecc_mask(i_len_log2);
    end

    // Record toward the back: a check request or a finished code.
    always_comb begin
        o_rec_valid    = i_accept && ((i_op == OP_CHECK) || last);
        o_rec.is_check = (i_op == OP_CHECK);
        o_rec.value    = (i_op == OP_CHECK) ? i_read_ecc : code;
    end

    // Parity state; a check word leaves the partial block untouched.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_idx <= '0;
        end else if (i_accept && (i_op == OP_DATA)) begin
            r_col <= last ? '0 : n_col;
            r_row <= last ? '0 : n_row;
            r_idx <= n_idx;
        end
    end

endmodule

// ===== rtl/core/nhe_queue.sv =====
// Two-entry record queue between the front and the back.
module nhe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  nhe_pkg::t_rec i_rec,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output nhe_pkg::t_rec o_head
);
    import nhe_pkg::*;

    t_rec       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

// ===== rtl/core/nhe_back.sv =====
// Back part: keeps the last code, decodes check syndromes and holds the output word.
module nhe_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [nhe_pkg::LenW-1:0]  i_len_log2,
    input  logic                      i_q_empty,
    input  nhe_pkg::t_rec             i_q_head,
    output logic                      o_q_pop,
    input  logic                      i_pop,
    output logic                      o_valid,
    output logic                      o_kind,
    output logic [nhe_pkg::EccW-1:0]  o_ecc_value,
    output logic [1:0]                o_status,
    output logic [nhe_pkg::AddrW-1:0] o_fix_byte_addr,
    output logic [nhe_pkg::BitW-1:0]  o_fix_bit
);
    import nhe_pkg::*;

    logic [EccW-1:0]  r_last;
    logic             r_valid;
    logic             r_kind;
    logic [EccW-1:0]  r_ecc;
    t_status          r_status;
    logic [AddrW-1:0] r_addr;
    logic [BitW-1:0]  r_bit;

    logic [EccW-1:0]  mask;
    logic [EccW-1:0]  syn;
    logic [EccW-1:0]  odd;
    logic [EccW-1:0]  lo;
    logic [EccW-1:0]  hi;
    t_status          status;
    logic [AddrW-1:0] addr;
    logic [BitW-1:0]  fbit;

    // Take the next record when the output register is free or being emptied.
    assign o_q_pop = !i_q_empty && (!r_valid || i_pop);

    // Syndrome classification against the kept code.
    always_comb begin
        mask   = ecc_mask(i_len_log2);
        syn    = (r_last ^ i_q_head.value) & mask;
        odd    = OddMask & mask;
        lo     = syn & odd;
        hi     = (syn >> 1) & odd;
        addr   = '0;
        fbit   = '0;
        if (syn == '0) begin
            status = ST_OK;
        end else if ((lo ^ hi) == odd) begin
            status = ST_CORRECTED;
            fbit   = {hi[4], hi[2], hi[0]};
            for (int i = 0; i < AddrW; i++) begin
                addr[i] = hi[6+2*i];
            end
        end else if ((syn & (syn - EccW'(1))) == '0) begin
            status = ST_ECC_BAD;
        end else begin
            status = ST_UNCORR;
        end
    end

    // Output register and kept code.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_last   <= '0;
            r_kind   <= KIND_GEN;
            r_ecc    <= '0;
            r_status <= ST_OK;
            r_addr   <= '0;
            r_bit    <= '0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
            if (i_q_head.is_check) begin
                r_kind   <= KIND_CHECK;
                r_ecc    <= '0;
                r_status <= status;
                r_addr   <= addr;
                r_bit    <= fbit;
            end else begin
                r_last   <= i_q_head.value;
                r_kind   <= KIND_GEN;
                r_ecc    <= i_q_head.value;
                r_status <= ST_OK;
                r_addr   <= '0;
                r_bit    <= '0;
            end
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_ecc_value     = r_ecc;
    assign o_status        = r_status;
    assign o_fix_byte_addr = r_addr;
    assign o_fix_bit       = r_bit;

    // A generated code word never carries a check outcome.
    a_gen_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind == KIND_GEN)) |-> ((r_status == ST_OK) && (r_addr == '0)))
        else $error("generated code word carries check fields");

    // A check word never carries a code value.
    a_check_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && (r_kind == KIND_CHECK)) |-> (r_ecc == '0))
        else $error("check word carries a code value");

    // A generated code becomes the kept code for later checks.
    a_keep_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && !i_q_head.is_check) |=> (r_last == r_ecc))
        else $error("generated code not kept");

endmodule

// ===== rtl/core/nand_hamming_ecc_gen_check_top.sv =====
// Top level of the NAND flash Hamming ECC generator and checker.
//
// Input queue side: push/full carries one word per cycle while full is low;
// i_op selects a data byte of the current block or a check of a code read back
// from storage. Result queue side: empty/pop; the oldest result sits on the o_
// ports while empty is low. A data byte gives a result only when it closes a
// block of 2^n bytes (the generated code); a check word always gives one result.
// A result's record is registered in the two-entry queue and then in the output
// register. Throughput: one word per cycle while full is low, as the parity
// update in the front and the syndrome decode in the back are combinational.
// A two-entry queue sits between front and back and an output register holds
// the result, so a stalled receiver lets up to three results build up before
// full is raised; words are never dropped.
// Reset clears all parities, the byte index and the kept code, and sets the
// block length register to 2^8 bytes. i_cfg_we writes the length (log2, values
// above MAX_LEN_LOG2 act as MAX_LEN_LOG2); write it only while the block is idle.
module nand_hamming_ecc_gen_check_top #(
    parameter int MAX_LEN_LOG2 = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [nhe_pkg::LenW-1:0]  i_cfg_wdata,
    input  logic                      push,
    output logic                      full,
    input  logic                      i_op,
    input  logic [nhe_pkg::ByteW-1:0] i_data_byte,
    input  logic [nhe_pkg::EccW-1:0]  i_read_ecc,
    output logic                      empty,
    input  logic                      pop,
    output logic                      o_kind,
    output logic [nhe_pkg::EccW-1:0]  o_ecc_value,
    output logic [1:0]                o_status,
    output logic [nhe_pkg::AddrW-1:0] o_fix_byte_addr,
    output logic [nhe_pkg::BitW-1:0]  o_fix_bit
);
    import nhe_pkg::*;

    logic [LenW-1:0] r_len;
    logic [LenW-1:0] eff_len;
    logic            accept;
    logic            rec_valid;
    t_rec            rec;
    logic            q_empty;
    logic            q_pop;
    t_rec            q_head;
    logic            out_valid;

    // Block length register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LenReset;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata;
        end
    end

    assign eff_len = (r_len > LenW'(MAX_LEN_LOG2)) ? LenW'(MAX_LEN_LOG2) : r_len;
    assign accept  = push && !full;
    assign empty   = !out_valid;

    nhe_front #(
        .MAX_LEN_LOG2(MAX_LEN_LOG2)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_len_log2  (eff_len),
        .i_accept    (accept),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .i_read_ecc  (i_read_ecc),
        .o_rec_valid (rec_valid),
        .o_rec       (rec)
    );

    nhe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_valid),
        .i_rec   (rec),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    nhe_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_len_log2      (eff_len),
        .i_q_empty       (q_empty),
        .i_q_head        (q_head),
        .o_q_pop         (q_pop),
        .i_pop           (pop),
        .o_valid         (out_valid),
        .o_kind          (o_kind),
        .o_ecc_value     (o_ecc_value),
        .o_status        (o_status),
        .o_fix_byte_addr (o_fix_byte_addr),
        .o_fix_bit       (o_fix_bit)
    );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the NAND flash Hamming ECC generator and checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nhe_pkg::*;

    localparam int MaxLenLog2   = 9;
    localparam int StallLimit   = 3000;
    localparam int SettleCycles = 4;
    localparam int HoldCycles   = 300;

    // Kinds of corruption applied to the kept code before a check word.
    typedef enum int {
        ErrNone,
        ErrFix,
        ErrCode,
        ErrDouble,
        ErrAny
    } t_err;

    // One result as the ports show it.
    typedef struct {
        logic            kind;
        logic [EccW-1:0] ecc;
        t_status         status;
        logic [AddrW-1:0] addr;
        logic [BitW-1:0] bitpos;
    } t_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [LenW-1:0]   i_cfg_wdata = '0;
    logic              push = 1'b0;
    logic              full;
    logic              i_op = OP_DATA;
    logic [ByteW-1:0]  i_data_byte = '0;
    logic [EccW-1:0]   i_read_ecc = '0;
    logic              empty;
    logic              pop = 1'b0;
    logic              o_kind;
    logic [EccW-1:0]   o_ecc_value;
    logic [1:0]        o_status;
    logic [AddrW-1:0]  o_fix_byte_addr;
    logic [BitW-1:0]   o_fix_bit;

    // Copy of the block state kept by the predictor.
    logic [LenW-1:0]   len_reg;
    logic [5:0]        col_par;
    logic [17:0]       row_par;
    logic [9:0]        byte_idx;
    logic [EccW-1:0]   kept_code;

    t_result pending_results[$];

    int tx_idle_pct = 19;
    int rx_idle_pct = 19;
    int hold_left = 0;
    int idle_cycles = 0;
    int mismatches = 0;
    int words_in = 0;
    int results_out = 0;
    int codes_seen = 0;
    int len_writes = 0;
    int status_seen[4] = '{0, 0, 0, 0};

    nand_hamming_ecc_gen_check_top #(
        .MAX_LEN_LOG2(MaxLenLog2)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_op           (i_op),
        .i_data_byte    (i_data_byte),
        .i_read_ecc     (i_read_ecc),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_ecc_value    (o_ecc_value),
        .o_status       (o_status),
        .o_fix_byte_addr(o_fix_byte_addr),
        .o_fix_bit      (o_fix_bit)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Lengths above the maximum act as the maximum.
    function automatic logic [LenW-1:0] eff_order(input logic [LenW-1:0] v);
        return (v > MaxLenLog2) ? LenW'(MaxLenLog2) : v;
    endfunction

    // The code is 2*(n+3) bits wide.
    function automatic logic [EccW-1:0] code_mask(input logic [LenW-1:0] n);
        return ~({EccW{1'b1}} << (2 * n + 6));
    endfunction

    // Folds one data byte into the parities; returns 1 when the block closes.
    function automatic bit fold_byte(input logic [ByteW-1:0] b, output t_result res);
        logic [LenW-1:0] n;
        logic            rp;
        int              i;
        n = eff_order(len_reg);
        rp = ^b;
        col_par ^= {b[7] ^ b[6] ^ b[5] ^ b[4], b[3] ^ b[2] ^ b[1] ^ b[0],
                    b[7] ^ b[6] ^ b[3] ^ b[2], b[5] ^ b[4] ^ b[1] ^ b[0],
                    b[7] ^ b[5] ^ b[3] ^ b[1], b[6] ^ b[4] ^ b[2] ^ b[0]};
        for (i = 0; i < n; i++) begin
            row_par[2 * i + byte_idx[i]] ^= rp;
        end
        res = '{KIND_GEN, '0, ST_OK, '0, '0};
        if (int'(byte_idx) + 1 >= (1 << n)) begin
            kept_code = {row_par, col_par} & code_mask(n);
            res.ecc = kept_code;
            col_par = '0;
            row_par = '0;
            byte_idx = '0;
            return 1'b1;
        end
        byte_idx = byte_idx + 10'd1;
        return 1'b0;
    endfunction

    // Classifies the syndrome of a read-back code against the kept one.
    function automatic t_result decode_check(input logic [EccW-1:0] rd);
        logic [EccW-1:0] m;
        logic [EccW-1:0] syn;
        logic [EccW-1:0] odd;
        logic [EccW-1:0] lo;
        logic [EccW-1:0] hi;
        t_result         res;
        int              i;
        m = code_mask(eff_order(len_reg));
        syn = (kept_code ^ rd) & m;
        odd = OddMask & m;
        lo = syn & odd;
        hi = (syn >> 1) & odd;
        res = '{KIND_CHECK, '0, ST_OK, '0, '0};
        if (syn == '0) begin
            res.status = ST_OK;
        end else if ((lo ^ hi) == odd) begin
            // Exactly one bit of every pair flipped: a single data bit is bad.
            res.status = ST_CORRECTED;
            res.bitpos = {hi[4], hi[2], hi[0]};
            for (i = 0; i < AddrW; i++) begin
                res.addr[i] = hi[6 + 2 * i];
            end
        end else if ($countones(syn) == 1) begin
            res.status = ST_ECC_BAD;
        end else begin
            res.status = ST_UNCORR;
        end
        return res;
    endfunction

    // Builds the bits to flip in the kept code for a check word.
    function automatic logic [EccW-1:0] error_pattern(input t_err cls);
        logic [LenW-1:0] n;
        logic [EccW-1:0] m;
        logic [EccW-1:0] p;
        int              w;
        int              a;
        int              c;
        int              i;
        n = eff_order(len_reg);
        m = code_mask(n);
        w = 2 * n + 6;
        // Bits above the code width are noise the block must ignore.
        p = EccW'($urandom()) & ~m;
        case (cls)
            ErrFix: begin
                for (i = 0; i < n + 3; i++) begin
                    p[2 * i + $urandom_range(0, 1)] = 1'b1;
                end
            end
            ErrCode: begin
                a = $urandom_range(0, w - 1);
                p[a] = 1'b1;
            end
            ErrDouble: begin
                a = $urandom_range(0, w - 1);
                c = (a + $urandom_range(1, w - 1)) % w;
                p[a] = 1'b1;
                p[c] = 1'b1;
            end
            ErrAny: begin
                p = EccW'($urandom());
            end
            default: begin
            end
        endcase
        return p;
    endfunction

    // Predictor and result check, both on the rising edge.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_result res;
        if (!i_rst_n) begin
            len_reg = LenReset;
            col_par = '0;
            row_par = '0;
            byte_idx = '0;
            kept_code = '0;
        end else begin
            if (pop && !empty) begin
                got = '{o_kind, o_ecc_value, t_status'(o_status), o_fix_byte_addr, o_fix_bit};
                results_out++;
                if (pending_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("mismatch at %0t: result with none expected, kind %0d ecc %06h",
                                 $realtime, got.kind, got.ecc);
                    end
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.ecc !== want.ecc ||
                        got.status !== want.status || got.addr !== want.addr ||
                        got.bitpos !== want.bitpos) begin
                        if (mismatches < 10) begin
                            $display("mismatch at %0t: want kind %0d ecc %06h st %0d addr %0d bit %0d",
                                     $realtime, want.kind, want.ecc, want.status, want.addr,
                                     want.bitpos);
                            $display("                  got  kind %0d ecc %06h st %0d addr %0d bit %0d",
                                     got.kind, got.ecc, got.status, got.addr, got.bitpos);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                len_reg = i_cfg_wdata;
            end
            if (push && !full) begin
                words_in++;
                if (i_op == OP_DATA) begin
                    if (fold_byte(i_data_byte, res)) begin
                        pending_results.push_back(res);
                        codes_seen++;
                    end
                end else begin
                    res = decode_check(i_read_ecc);
                    pending_results.push_back(res);
                    status_seen[res.status]++;
                end
            end
        end
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
    end

    // Receiver: random pops, with a counted hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            pop <= 1'b0;
            hold_left--;
        end else begin
            pop <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Watchdog on cycles without any accepted word or popped result.
    initial begin
        wait (idle_cycles >= StallLimit);
        $display("timeout: no word moved for %0d cycles, %0d results outstanding",
                 StallLimit, pending_results.size());
        $display("CHECK FAILED");
        $finish;
    end

    // Offers one word and returns at the edge that accepts it.
    task automatic send_word(input logic op, input logic [ByteW-1:0] b,
                             input logic [EccW-1:0] rd, input bit rel);
        int gap;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 5);
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_op <= op;
        i_data_byte <= b;
        // A relative code is applied to the kept code as it stands now.
        i_read_ecc <= rel ? (rd ^ kept_code) : rd;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic send_block();
        int k;
        for (k = 0; k < (1 << eff_order(len_reg)); k++) begin
            send_word(OP_DATA, ByteW'($urandom()), EccW'($urandom()), 1'b0);
        end
    endtask

    task automatic send_check(input t_err cls);
        send_word(OP_CHECK, ByteW'($urandom()), error_pattern(cls), 1'b1);
    endtask

    // Stops sending and waits until every expected result has arrived.
    task automatic wait_results();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_len(input logic [LenW-1:0] v);
        wait_results();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        len_writes++;
    endtask

    // Checks before any block see a kept code of zero; high read bits are ignored.
    task automatic test_check_before_block();
        send_word(OP_CHECK, 8'h00, 24'h000000, 1'b0);
        send_word(OP_CHECK, 8'hFF, 24'hFFFFFF, 1'b0);
    endtask

    // One-byte blocks with extreme bytes, then every check outcome.
    task automatic test_one_byte_blocks();
        write_len(4'd0);
        send_word(OP_DATA, 8'h00, 24'hFFFFFF, 1'b0);
        send_word(OP_DATA, 8'hFF, 24'h000000, 1'b0);
        send_word(OP_DATA, 8'h80, 24'hAAAAAA, 1'b0);
        send_word(OP_DATA, 8'h01, 24'h555555, 1'b0);
        send_check(ErrNone);
        send_check(ErrFix);
        send_check(ErrCode);
        send_check(ErrDouble);
    endtask

    // A shorter length set mid-block ends the block at the next byte.
    task automatic test_length_change();
        write_len(4'd9);
        send_word(OP_DATA, 8'h5A, 24'h0, 1'b0);
        send_word(OP_DATA, 8'hC3, 24'h0, 1'b0);
        send_word(OP_DATA, 8'h7E, 24'h0, 1'b0);
        write_len(4'd1);
        send_word(OP_DATA, 8'h99, 24'h0, 1'b0);
        send_check(ErrFix);
    endtask

    // A check in the middle of a block uses the previous code.
    task automatic test_check_mid_block();
        write_len(4'd2);
        send_word(OP_DATA, 8'h12, 24'h0, 1'b0);
        send_word(OP_DATA, 8'hF0, 24'h0, 1'b0);
        send_check(ErrFix);
        send_word(OP_DATA, 8'h0F, 24'h0, 1'b0);
        send_word(OP_DATA, 8'hED, 24'h0, 1'b0);
        send_check(ErrNone);
    endtask

    // The receiver holds off while the sender keeps offering, so full must rise.
    task automatic test_receiver_holdoff();
        int k;
        write_len(4'd0);
        tx_idle_pct = 0;
        @(posedge i_clk);
        hold_left = HoldCycles;
        for (k = 0; k < 40; k++) begin
            if (k % 5 == 4) begin
                send_check(t_err'($urandom_range(0, 4)));
            end else begin
                send_word(OP_DATA, ByteW'($urandom()), EccW'($urandom()), 1'b0);
            end
        end
        tx_idle_pct = 19;
        // The sender now pauses until the backlog has drained.
        wait_results();
    endtask

    // A stretch with neither side idling.
    task automatic test_no_idle_stretch();
        int k;
        write_len(4'd1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (k = 0; k < 20; k++) begin
            send_block();
            send_check(t_err'($urandom_range(0, 4)));
        end
        tx_idle_pct = 19;
        rx_idle_pct = 19;
    endtask

    // An out-of-range length acts as the largest block.
    task automatic test_longest_block();
        write_len(4'd15);
        send_block();
        send_check(ErrFix);
        send_check(ErrFix);
        send_check(ErrCode);
    endtask

    // Mostly whole blocks followed by checks, with some stray words mixed in.
    task automatic test_random_mix(input int n_words);
        int start;
        int r;
        int k;
        start = words_in;
        while (words_in - start < n_words) begin
            r = $urandom_range(0, 9);
            write_len((r < 8) ? LenW'(r % 5) : LenW'(r - 3));
            repeat ($urandom_range(2, 5)) begin
                if ($urandom_range(0, 99) < 85) begin
                    send_block();
                    repeat ($urandom_range(1, 2)) send_check(t_err'($urandom_range(0, 4)));
                end else begin
                    for (k = 0; k < $urandom_range(1, 4); k++) begin
                        send_word(1'($urandom()), ByteW'($urandom()), EccW'($urandom()),
                                  1'b0);
                    end
                end
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_check_before_block();
        test_one_byte_blocks();
        test_length_change();
        test_check_mid_block();
        test_receiver_holdoff();
        test_no_idle_stretch();
        test_longest_block();
        test_random_mix(300);
        wait_results();
        $display("Run covered %0d words in, %0d results out, %0d codes, %0d length writes.",
                 words_in, results_out, codes_seen, len_writes);
        $display("Checks: %0d clean, %0d correctable, %0d code errors, %0d uncorrectable.",
                 status_seen[ST_OK], status_seen[ST_CORRECTED], status_seen[ST_ECC_BAD],
                 status_seen[ST_UNCORR]);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
